@@ rtl/core/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared constants and the beat record passed from the front to the back part.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned FracBitsDefault = 12;
  localparam int unsigned CompW           = 8;
  localparam int unsigned HueW            = 15;
  localparam int unsigned SatW            = 13;
  localparam int unsigned InDataW         = 24;
  localparam int unsigned OutDataW        = 40;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CompW-1:0] mx;
    logic [CompW-1:0] spread;
    logic [CompW-1:0] dmag;
    logic             dneg;
    sector_t          sector;
  } cls_t;

endpackage

@@ rtl/core/rgbhsv_front.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV front part
// Finds maximum, spread, sector and the signed difference of one pixel.
// ----------------------------------------------------------------------------
module rgbhsv_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgbhsv_pkg::CompW-1:0] red,
  input  logic [rgbhsv_pkg::CompW-1:0] green,
  input  logic [rgbhsv_pkg::CompW-1:0] blue,
  output logic                        cls_valid,
  input  logic                        cls_ready,
  output rgbhsv_pkg::cls_t            cls
);
  import rgbhsv_pkg::*;

  logic             valid_r;
  cls_t             cls_r;
  cls_t             cls_nxt;
  logic [CompW-1:0] mx, mn;
  logic [CompW:0]   d;

  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    if (red == mx) begin
      cls_nxt.sector = SECT_RED;
      d = {1'b0, green} - {1'b0, blue};
    end else if (green == mx) begin
      cls_nxt.sector = SECT_GREEN;
      d = {1'b0, blue} - {1'b0, red};
    end else begin
      cls_nxt.sector = SECT_BLUE;
      d = {1'b0, red} - {1'b0, green};
    end
    cls_nxt.mx     = mx;
    cls_nxt.spread = mx - mn;
    cls_nxt.dneg   = d[CompW];
    cls_nxt.dmag   = d[CompW] ? CompW'(-d) : d[CompW-1:0];
  end

  assign in_ready  = !valid_r || cls_ready;
  assign cls_valid = valid_r;
  assign cls       = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

@@ rtl/core/rgbhsv_queue.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module rgbhsv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  rgbhsv_pkg::cls_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output rgbhsv_pkg::cls_t rd_data
);
  import rgbhsv_pkg::*;

  cls_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd) |=> (cnt_r == 2'd2))
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wp_r == rp_r))
    else $error("empty queue pointers differ");

endmodule

@@ rtl/core/rgbhsv_back.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV back part
// Pipelined restoring dividers for saturation and hue, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rgbhsv_back #(
  parameter int unsigned FRAC_BITS = rgbhsv_pkg::FracBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cls_valid,
  output logic                               cls_ready,
  input  rgbhsv_pkg::cls_t                   cls,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rgbhsv_pkg::OutDataW-1:0]    out_tdata
);
  import rgbhsv_pkg::*;

  localparam int unsigned NumW = CompW + FRAC_BITS;
  localparam int unsigned Stg  = NumW;
  localparam int unsigned HW   = FRAC_BITS + 4;

  logic             v_r   [Stg+1];
  logic [NumW-1:0]  sn_r  [Stg+1];
  logic [CompW:0]   sr_r  [Stg+1];
  logic [NumW-1:0]  hn_r  [Stg+1];
  logic [CompW:0]   hr_r  [Stg+1];
  cls_t             c_r   [Stg+1];
  logic             adv;
  logic             ovalid_r;
  logic [OutDataW-1:0] odata_r;
  logic [OutDataW-1:0] odata_nxt;
  logic [HW-1:0]    h;
  logic [HW-1:0]    base;
  logic             gray;

  assign adv       = !ovalid_r || out_tready || !v_r[Stg];
  assign cls_ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_r[0] <= {cls.spread, FRAC_BITS'(0)};
      sr_r[0] <= '0;
      hn_r[0] <= {cls.dmag, FRAC_BITS'(0)};
      hr_r[0] <= '0;
      c_r[0]  <= cls;
    end
  end

  for (genvar s = 0; s < Stg; s++) begin : g_stage
    logic [CompW+1:0] st, ht;
    always_comb begin
      st = {sr_r[s], sn_r[s][NumW-1]} - {2'b0, c_r[s].mx};
      ht = {hr_r[s], hn_r[s][NumW-1]} - {2'b0, c_r[s].spread};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[s+1]  <= c_r[s];
        sn_r[s+1] <= {sn_r[s][NumW-2:0], !st[CompW+1]};
        sr_r[s+1] <= st[CompW+1] ? {sr_r[s][CompW-1:0], sn_r[s][NumW-1]} : st[CompW:0];
        hn_r[s+1] <= {hn_r[s][NumW-2:0], !ht[CompW+1]};
        hr_r[s+1] <= ht[CompW+1] ? {hr_r[s][CompW-1:0], hn_r[s][NumW-1]} : ht[CompW:0];
      end
    end
  end

  for (genvar s = 0; s <= Stg; s++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= (s == 0) ? cls_valid : v_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_comb begin
    gray = (c_r[Stg].spread == '0);
    case (c_r[Stg].sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HW'(2) << FRAC_BITS;
      SECT_BLUE:  base = HW'(4) << FRAC_BITS;
      default:    base = '0;
    endcase
    if (c_r[Stg].dneg) begin
      h = base - HW'(hn_r[Stg]);
      if (c_r[Stg].sector == SECT_RED && hn_r[Stg] != '0) h = h + (HW'(6) << FRAC_BITS);
    end else begin
      h = base + HW'(hn_r[Stg]);
    end
    odata_nxt = '0;
    odata_nxt[HueW-1:0]           = gray ? '0 : HueW'(h);
    odata_nxt[HueW+SatW-1:HueW]   = gray ? '0 : SatW'(sn_r[Stg]);
    odata_nxt[HueW+SatW+CompW-1:HueW+SatW] = c_r[Stg].mx;
    odata_nxt[HueW+SatW+CompW]    = gray;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (!ovalid_r || out_tready) begin
      ovalid_r <= v_r[Stg];
    end
  end

  always_ff @(posedge clk) begin
    if (!ovalid_r || out_tready) odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> $stable(odata_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && odata_r[HueW+SatW+CompW]) |-> (odata_r[HueW+SatW-1:0] == '0))
    else $error("gray pixel with nonzero hue or saturation");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready && v_r[Stg]) |-> !adv)
    else $error("pipeline advanced into a full output");

endmodule

@@ rtl/core/rgb_to_hsv_pixel.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Throughput is one pixel per cycle while out_tready holds the output open;
// a low out_tready stalls the pipeline. The quotient pipeline of 8 + FRAC_BITS
// divider stages sets the latency. Synchronous active-low reset empties every stage.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel #(
  parameter int unsigned FRAC_BITS = rgbhsv_pkg::FracBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rgbhsv_pkg::InDataW-1:0]  in_tdata,   // red, green, blue
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rgbhsv_pkg::OutDataW-1:0] out_tdata   // hue, saturation, value, is_gray
);
  import rgbhsv_pkg::*;

  logic cf_valid, cf_ready, qb_valid, qb_ready;
  cls_t cf, qb;

  rgbhsv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .red(in_tdata[7:0]), .green(in_tdata[15:8]), .blue(in_tdata[23:16]),
    .cls_valid(cf_valid), .cls_ready(cf_ready), .cls(cf)
  );

  rgbhsv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(cf_valid), .wr_ready(cf_ready), .wr_data(cf),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb)
  );

  rgbhsv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cls_valid(qb_valid), .cls_ready(qb_ready), .cls(qb),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
